### rtl/timed_hit_event_builder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timed hit event builder
// Shorthand for clocked implication checks, same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef TIMED_HIT_EVENT_BUILDER_MACROS_SVH
`define TIMED_HIT_EVENT_BUILDER_MACROS_SVH

// consequent holds in the cycle of the antecedent
`define TBEB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define TBEB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tbeb_pkg.sv
// ----------------------------------------------------------------------------
// Timed hit event builder package
// Transfer types, hit memory entry and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tbeb_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_EVENT_WINDOW = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALIB_CH0    = 3'd1;

   localparam logic [31:0] WINDOW_RESET = 32'd1000;
   localparam logic [63:0] CALIB_RESET  = 64'h0001_0000_0000_0000;

   localparam logic OP_HIT   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic        op;
      logic [1:0]  hit_channel;
      logic [15:0] adc_energy;
      logic [31:0] time_high;
      logic [31:0] time_low;
   } req_type;

   typedef struct packed {
      logic [1:0]         out_channel;
      logic [15:0]        out_adc_energy;
      logic signed [31:0] calibrated_energy;
      logic [31:0]        out_time_high;
      logic [31:0]        out_time_low;
      logic [4:0]         event_size;
      logic               last_of_event;
      logic               hits_dropped;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  channel;
      logic [15:0] adc;
      logic [31:0] calibrated;
      logic [63:0] time_stamp;
   } hit_entry_type;

endpackage

`default_nettype wire

### rtl/tbeb_calib.sv
// ----------------------------------------------------------------------------
// Energy calibration unit
// Registered adc * gain, then offset add, truncation toward zero and
// saturation to a signed 32-bit value (Q16.16 gain and offset).
// ----------------------------------------------------------------------------
`default_nettype none

module tbeb_calib (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire logic [15:0]        adc,
   input  wire logic signed [31:0] gain,
   input  wire logic signed [31:0] offset,
   input  wire logic               zero,
   output logic signed [31:0]      result
);

   logic signed [48:0] product_in;
   logic signed [48:0] product_ff;
   logic signed [31:0] offset_ff;
   logic               zero_ff;
   logic signed [48:0] sum;
   logic signed [32:0] floor_part;
   logic signed [32:0] whole;

   assign product_in = $signed({1'b0, adc}) * gain;

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
         offset_ff  <= offset;
         zero_ff    <= zero;
      end
   end

   assign sum        = product_ff + {{17{offset_ff[31]}}, offset_ff};
   assign floor_part = sum[48:16];
   assign whole      = floor_part + 33'(sum[48] && (sum[15:0] != 16'd0));

   always_comb begin
      priority if (zero_ff) begin
         result = '0;
      end else if (whole[32] != whole[31]) begin
         result = whole[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         result = whole[31:0];
      end
   end

endmodule

`default_nettype wire

### rtl/tbeb_hit_mem.sv
// ----------------------------------------------------------------------------
// Hit memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tbeb_hit_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_W-1:0]      wr_addr,
   input  wire tbeb_pkg::hit_entry_type wr_data,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_W-1:0]      rd_addr,
   output tbeb_pkg::hit_entry_type     rd_data
);

   tbeb_pkg::hit_entry_type hit_mem_ff [DEPTH];
   tbeb_pkg::hit_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hit_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= hit_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/timed_hit_event_builder.sv
// ----------------------------------------------------------------------------
// Timed hit event builder
// Groups detector hits into coincidence events, calibrates each hit and
// sends every stored hit of a closed event as one result.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  tbeb_pkg::req_type
//   rsp       out        rsp_valid / rsp_stall  tbeb_pkg::rsp_type
//   csr       in         csr_write              csr_index, csr_wdata
//
// A hit that joins or opens an event goes through the transfer plus the
// multiply, then the offset add and the write into the hit memory.
// Closing an event reads each stored hit from the memory, one read at a time,
// then loads it into the output register; a flush with nothing open stays idle.
// Reset clears control state and loads register defaults; no clearing pass.
// rsp_stall holds the output register and pauses memory reads.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_hit_event_builder #(
   parameter int MAX_HITS     = 16,
   parameter int NUM_CHANNELS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire tbeb_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output tbeb_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_write,
   input  wire logic [tbeb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [tbeb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_HITS + 1);
   localparam int ADDR_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_STORE} state_type;

   logic [31:0] window_ff;
   logic [63:0] calib_ff [NUM_CHANNELS];

   state_type               state_ff, state_in;
   tbeb_pkg::req_type       hit_ff, hit_in;
   logic                    open_ff, open_in;
   logic [CNT_W-1:0]        stored_ff, stored_in;
   logic                    overflow_ff, overflow_in;
   logic [63:0]             start_ff, start_in;
   logic [CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic                    pend_last_ff, pend_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tbeb_pkg::rsp_type       rsp_ff, rsp_in;

   logic                    accept;
   logic [63:0]             req_time;
   logic                    joins;
   logic                    has_event;
   logic                    rsp_free;
   logic                    rd_more;
   logic                    issue;
   logic                    stored_full;
   logic [CNT_W-1:0]        rd_next;

   logic                    mem_we;
   tbeb_pkg::hit_entry_type mem_wdata;
   tbeb_pkg::hit_entry_type mem_rdata;

   logic                    ch_ok;
   logic [63:0]             calib_sel;
   logic signed [31:0]      calib_result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= tbeb_pkg::WINDOW_RESET;
      end else if (csr_write && csr_index == tbeb_pkg::CSR_EVENT_WINDOW) begin
         window_ff <= csr_wdata[31:0];
      end
   end

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_calib_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            calib_ff[c] <= tbeb_pkg::CALIB_RESET;
         end else if (csr_write &&
                      csr_index == tbeb_pkg::CSR_INDEX_W'(tbeb_pkg::CSR_CALIB_CH0 + c)) begin
            calib_ff[c] <= csr_wdata;
         end
      end
   end

   // calibration of the incoming hit
   assign ch_ok     = {1'b0, req_data.hit_channel} < 3'(NUM_CHANNELS);
   assign calib_sel = ch_ok ? calib_ff[req_data.hit_channel[CH_W-1:0]] : '0;

   tbeb_calib u_calib (
      .clock  (clock),
      .load   (accept),
      .adc    (req_data.adc_energy),
      .gain   ($signed(calib_sel[63:32])),
      .offset ($signed(calib_sel[31:0])),
      .zero   (!ch_ok),
      .result (calib_result)
   );

   // hit memory
   assign mem_wdata.channel    = hit_ff.hit_channel;
   assign mem_wdata.adc        = hit_ff.adc_energy;
   assign mem_wdata.calibrated = calib_result;
   assign mem_wdata.time_stamp = {hit_ff.time_high, hit_ff.time_low};

   tbeb_hit_mem #(
      .DEPTH  (MAX_HITS),
      .ADDR_W (ADDR_W)
   ) u_hit_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (stored_ff[ADDR_W-1:0]),
      .wr_data (mem_wdata),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (mem_rdata)
   );

   // control
   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign req_time    = {req_data.time_high, req_data.time_low};
   assign joins       = (req_time < start_ff) || ((req_time - start_ff) < {32'd0, window_ff});
   assign has_event   = (stored_ff != '0);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rd_more     = (rd_idx_ff != stored_ff);
   assign issue       = (state_ff == ST_EMIT) && rd_more && !rd_pend_ff && rsp_free;
   assign stored_full = (stored_ff == CNT_W'(MAX_HITS));
   assign rd_next     = rd_idx_ff + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      hit_in       = hit_ff;
      open_in      = open_ff;
      stored_in    = stored_ff;
      overflow_in  = overflow_ff;
      start_in     = start_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = issue;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rd_pend_ff) begin
         rsp_valid_in             = 1'b1;
         rsp_in.out_channel       = mem_rdata.channel;
         rsp_in.out_adc_energy    = mem_rdata.adc;
         rsp_in.calibrated_energy = $signed(mem_rdata.calibrated);
         rsp_in.out_time_high     = mem_rdata.time_stamp[63:32];
         rsp_in.out_time_low      = mem_rdata.time_stamp[31:0];
         rsp_in.event_size        = 5'(stored_ff);
         rsp_in.last_of_event     = pend_last_ff;
         rsp_in.hits_dropped      = overflow_ff;
      end
      if (issue) begin
         rd_idx_in    = rd_next;
         pend_last_in = (rd_next == stored_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hit_in = req_data;
               if (req_data.op == tbeb_pkg::OP_FLUSH) begin
                  if (has_event) begin
                     state_in = ST_EMIT;
                  end
               end else if (!has_event || joins) begin
                  open_in  = !has_event;
                  state_in = ST_STORE;
               end else begin
                  open_in  = 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rd_more && !rd_pend_ff) begin
               stored_in   = '0;
               overflow_in = 1'b0;
               rd_idx_in   = '0;
               state_in    = (hit_ff.op == tbeb_pkg::OP_FLUSH) ? ST_IDLE : ST_STORE;
            end
         end
         ST_STORE: begin
            if (open_ff) begin
               start_in = {hit_ff.time_high, hit_ff.time_low};
            end
            if (stored_full) begin
               overflow_in = 1'b1;
            end else begin
               mem_we    = 1'b1;
               stored_in = stored_ff + CNT_W'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= 1'b0;
         stored_ff    <= '0;
         overflow_ff  <= 1'b0;
         start_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         stored_ff    <= stored_in;
         overflow_ff  <= overflow_in;
         start_ff     <= start_in;
         rd_idx_ff    <= rd_idx_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hit_ff       <= hit_in;
      pend_last_ff <= pend_last_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### rtl/tbeb_checker.sv
// ----------------------------------------------------------------------------
// Timed hit event builder port checker
// Watches the transfer ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_hit_event_builder_macros.svh"

module tbeb_port_assertions (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire tbeb_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire tbeb_pkg::rsp_type rsp_data
);

   `TBEB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   `TBEB_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   `TBEB_ASSERT_NEXT(a_hit_busy, clock, reset, req_valid && !req_stall && req_data.op == tbeb_pkg::OP_HIT, req_stall, "hit transfer not followed by stall")

   `TBEB_ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_valid && !rsp_stall, !rsp_valid, "result follows a transfer without memory read")

endmodule

bind timed_hit_event_builder tbeb_port_assertions u_tbeb_port_assertions (.*);

`default_nettype wire

### verif/tbeb_checker.sv
// ----------------------------------------------------------------------------
// Event builder result checker
// Watches the register port and both transfer channels, predicts every
// result of each accepted transfer with its own copy of the grouping,
// calibration and overflow rules, and compares each result field by field
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tbeb_checker
   import tbeb_pkg::*;
#(
   parameter int MAX_HITS     = 16,
   parameter int NUM_CHANNELS = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire req_type                req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire rsp_type                rsp_data,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          mismatch_count,
   output int                          pending_results,
   output int                          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ENERGY_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint ENERGY_MIN = -64'sh0000_0000_8000_0000;

   logic [31:0]   window;
   logic [63:0]   calib [NUM_CHANNELS];
   hit_entry_type open_hits [MAX_HITS];
   logic [63:0]   start_time;
   int unsigned   hit_count;
   logic          overflow;
   rsp_type       expected_hits [$];
   int            mismatches = 0;
   int            checked = 0;

   assign mismatch_count  = mismatches;
   assign results_checked = checked;

   function automatic logic [31:0] calibrate_energy(input logic [1:0] ch,
                                                    input logic [15:0] adc);
      longint gain;
      longint offset;
      longint sum;
      longint whole;
      if (ch >= NUM_CHANNELS) return '0;
      gain   = longint'(signed'(calib[ch][63:32]));
      offset = longint'(signed'(calib[ch][31:0]));
      sum    = longint'(adc) * gain + offset;
      // truncate toward zero
      if (sum < 0) whole = -((-sum) >>> 16);
      else whole = sum >>> 16;
      if (whole > ENERGY_MAX) whole = ENERGY_MAX;
      if (whole < ENERGY_MIN) whole = ENERGY_MIN;
      return whole[31:0];
   endfunction

   function automatic void store_hit(input req_type item);
      if (hit_count >= MAX_HITS) begin
         overflow = 1'b1;
         return;
      end
      open_hits[hit_count].channel    = item.hit_channel;
      open_hits[hit_count].adc        = item.adc_energy;
      open_hits[hit_count].calibrated = calibrate_energy(item.hit_channel, item.adc_energy);
      open_hits[hit_count].time_stamp = {item.time_high, item.time_low};
      hit_count++;
   endfunction

   function automatic void close_event();
      rsp_type r;
      for (int k = 0; k < hit_count; k++) begin
         r.out_channel       = open_hits[k].channel;
         r.out_adc_energy    = open_hits[k].adc;
         r.calibrated_energy = open_hits[k].calibrated;
         r.out_time_high     = open_hits[k].time_stamp[63:32];
         r.out_time_low      = open_hits[k].time_stamp[31:0];
         r.event_size        = 5'(hit_count);
         r.last_of_event     = (k + 1 == hit_count);
         r.hits_dropped      = overflow;
         expected_hits       = {expected_hits, r};
      end
      hit_count = 0;
      overflow  = 1'b0;
   endfunction

   function automatic void build_events(input req_type item);
      logic [63:0] stamp;
      logic        joins;
      stamp = {item.time_high, item.time_low};
      if (item.op == OP_FLUSH) begin
         close_event();
         return;
      end
      if (hit_count == 0) begin
         overflow   = 1'b0;
         start_time = stamp;
         store_hit(item);
         return;
      end
      joins = (stamp < start_time) || ((stamp - start_time) < {32'd0, window});
      if (!joins) begin
         close_event();
         start_time = stamp;
      end
      store_hit(item);
   endfunction

   function automatic void write_register(input logic [CSR_INDEX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] value);
      if (index == CSR_EVENT_WINDOW)
         window = value[31:0];
      else if (index >= CSR_CALIB_CH0 && index < CSR_CALIB_CH0 + NUM_CHANNELS)
         calib[index - CSR_CALIB_CH0] = value;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t ns: %s", $time, msg);
   endfunction

   function automatic void compare_field(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want)
         note_mismatch($sformatf("%s expected %0h got %0h", field, want, got));
   endfunction

   function automatic void check_result(input rsp_type got);
      rsp_type want;
      checked++;
      if (expected_hits.size() == 0) begin
         note_mismatch($sformatf("result with nothing pending: channel %0d time %0h_%0h",
                                 got.out_channel, got.out_time_high, got.out_time_low));
         return;
      end
      want = expected_hits.pop_front();
      compare_field("out_channel", want.out_channel, got.out_channel);
      compare_field("out_adc_energy", want.out_adc_energy, got.out_adc_energy);
      compare_field("calibrated_energy", want.calibrated_energy, got.calibrated_energy);
      compare_field("out_time_high", want.out_time_high, got.out_time_high);
      compare_field("out_time_low", want.out_time_low, got.out_time_low);
      compare_field("event_size", want.event_size, got.event_size);
      compare_field("last_of_event", want.last_of_event, got.last_of_event);
      compare_field("hits_dropped", want.hits_dropped, got.hits_dropped);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         window = WINDOW_RESET;
         for (int c = 0; c < NUM_CHANNELS; c++) calib[c] = CALIB_RESET;
         start_time = '0;
         hit_count  = 0;
         overflow   = 1'b0;
         expected_hits.delete();
      end else begin
         if (csr_write) write_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) build_events(req_data);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
      pending_results <= expected_hits.size();
   end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Timed hit event builder testbench
// Drives hits and flushes through the event builder in bursts against a
// receiver that stalls on changing patterns. A directed opening covers
// window edges, earlier timestamps, a full event and the top of the time
// range; random events with random content then run under several window
// and calibration settings, extremes included. The checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tbeb_pkg::*;

   localparam int MAX_HITS      = 16;
   localparam int NUM_CHANNELS  = 4;
   localparam int NUM_SETTINGS  = 6;
   localparam int ITEMS_EACH    = 73;
   localparam int SETTLE_CYCLES = 2 * MAX_HITS + 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE =
      CSR_INDEX_W'(CSR_CALIB_CH0 + NUM_CHANNELS);

   typedef enum logic [1:0] {RX_FLOWING, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_pattern_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int             mismatch_count;
   int             pending_results;
   int             results_checked;
   int unsigned    cycle_count = 0;
   int             burst_left  = 0;
   int             transfers   = 0;
   logic [63:0]    event_clock = 64'd5000;
   rx_pattern_type rx_pattern  = RX_FLOWING;
   int             rx_left     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   timed_hit_event_builder #(
      .MAX_HITS     (MAX_HITS),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_write, .csr_index, .csr_wdata
   );

   tbeb_checker #(
      .MAX_HITS     (MAX_HITS),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_write, .csr_index, .csr_wdata,
      .mismatch_count, .pending_results, .results_checked
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         rx_left    = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_pattern)
         RX_FLOWING: rsp_stall <= 1'b0;
         RX_LIGHT:   rsp_stall <= ($urandom_range(0, 4) == 0);
         RX_HEAVY:   rsp_stall <= ($urandom_range(0, 2) != 0);
         default:    rsp_stall <= (rx_left % 8) < 5;
      endcase
   end

   function automatic logic [15:0] energy_sample();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type make_hit(input logic [1:0] ch, input logic [15:0] adc,
                                        input logic [63:0] stamp);
      req_type item;
      item.op          = OP_HIT;
      item.hit_channel = ch;
      item.adc_energy  = adc;
      item.time_high   = stamp[63:32];
      item.time_low    = stamp[31:0];
      return item;
   endfunction

   function automatic req_type random_item();
      req_type item;
      item.op          = 1'($urandom);
      item.hit_channel = 2'($urandom);
      item.adc_energy  = energy_sample();
      item.time_high   = $urandom;
      item.time_low    = $urandom;
      return item;
   endfunction

   function automatic req_type flush_item();
      req_type item;
      item    = random_item();
      item.op = OP_FLUSH;
      return item;
   endfunction

   function automatic logic [63:0] pick_calib();
      logic [31:0] gain;
      logic [31:0] offset;
      case ($urandom_range(0, 2))
         0: return {$urandom, $urandom};
         1: begin
            gain   = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            offset = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            return {gain, offset};
         end
         default: return CALIB_RESET;
      endcase
   endfunction

   // hold between bursts
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
      end
   endtask

   task automatic send_item(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      transfers++;
      pace();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic send_event(input logic [31:0] win, output int hits);
      logic [63:0] start_at;
      logic [63:0] stamp;
      logic [63:0] back;
      hits = ($urandom_range(0, 4) == 0) ? $urandom_range(MAX_HITS - 2, MAX_HITS + 4)
                                         : $urandom_range(1, 6);
      start_at = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} : event_clock;
      for (int k = 0; k < hits; k++) begin
         if (k == 0) begin
            stamp = start_at;
         end else if (win == 0 || $urandom_range(0, 4) == 0) begin
            back  = 64'($urandom_range(1, 5000));
            stamp = (start_at >= back) ? start_at - back : start_at;
         end else begin
            stamp = start_at + (($urandom_range(0, 7) == 0) ? win - 1 : $urandom % win);
         end
         send_item(make_hit(2'($urandom), energy_sample(), stamp));
      end
      event_clock = start_at + win + $urandom_range(0, 2);
   endtask

   task automatic random_items(input int target, input logic [31:0] win);
      int sent;
      int hits;
      sent = 0;
      while (sent < target) begin
         case ($urandom_range(0, 9))
            0: begin
               send_item(flush_item());
               sent++;
            end
            1: begin
               send_item(random_item());
               sent++;
            end
            default: begin
               send_event(win, hits);
               sent += hits;
            end
         endcase
      end
   endtask

   task automatic configure(input int setting, output logic [31:0] win);
      logic [63:0] calib_set [NUM_CHANNELS];
      case (setting)
         0:       win = '0;
         1:       win = '1;
         2:       win = 32'd1;
         3:       win = WINDOW_RESET;
         4:       win = $urandom_range(2, 5000);
         default: win = $urandom;
      endcase
      for (int c = 0; c < NUM_CHANNELS; c++) calib_set[c] = pick_calib();
      if (setting == 0) begin
         calib_set[0] = 64'h7FFF_FFFF_7FFF_FFFF;
         calib_set[1] = 64'h8000_0000_8000_0000;
         calib_set[2] = 64'hFFFF_0000_FFFE_8000;
         calib_set[3] = 64'h0000_0000_7FFF_FFFF;
      end
      write_register(CSR_EVENT_WINDOW, {32'd0, win});
      for (int c = 0; c < NUM_CHANNELS; c++)
         write_register(CSR_CALIB_CH0 + CSR_INDEX_W'(c), calib_set[c]);
      if (setting == 2)
         for (int i = CSR_SPARE; i < 2 ** CSR_INDEX_W; i++)
            write_register(CSR_INDEX_W'(i), {$urandom, $urandom});
   endtask

   initial begin
      logic [31:0] win;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(flush_item());
      send_item(make_hit(2'd0, 16'h0000, 64'd0));
      send_item(make_hit(2'd1, 16'hFFFF, 64'd999));
      send_item(make_hit(2'd2, 16'd1234, 64'd1000));
      send_item(make_hit(2'd3, 16'd5, 64'd500));
      for (int k = 0; k < MAX_HITS - 1; k++)
         send_item(make_hit(2'(k), 16'($urandom), 64'd1001 + k));
      send_item(make_hit(2'd0, 16'h8000, 64'hFFFF_FFFF_FFFF_FFFB));
      send_item(make_hit(2'd1, 16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF));
      send_item(make_hit(2'd2, 16'h0001, 64'hFFFF_FFFF_0000_0000));
      send_item(flush_item());

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         drain();
         configure(s, win);
         random_items(ITEMS_EACH, win);
      end
      send_item(flush_item());
      drain();

      $display("Run covered %0d transfers over %0d register settings, %0d results checked.",
               transfers, NUM_SETTINGS + 1, results_checked);
      if (mismatch_count == 0 && pending_results == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
